// File: rtl/assert_macros.svh
// Assertion macros shared by the string unescaper modules.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by the decoder front end, the queue, the serializer and the top level.
package jsu_pkg;

  // Status codes carried by every result.
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Largest number of bytes one input byte can produce.
  localparam int unsigned MaxBytes = 6;

  // One decoded input byte: its output bytes, their count and the status.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               nbytes;
    logic [1:0]               status;
  } jsu_entry_t;

endpackage

// File: rtl/jsu_front.sv
// Decoder front end: parses escapes and \u sequences and encodes UTF-8.
// Produces one queue entry per accepted byte; depends on jsu_pkg.
`include "assert_macros.svh"

module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output jsu_entry_t entry_o
);

  // Decoder modes.
  localparam logic [2:0] M_NORMAL       = 3'd0;
  localparam logic [2:0] M_ESC          = 3'd1;
  localparam logic [2:0] M_HEX1         = 3'd2;
  localparam logic [2:0] M_AFTER_HIGH   = 3'd3;
  localparam logic [2:0] M_AFTER_HIGH_BS = 3'd4;
  localparam logic [2:0] M_HEX2         = 3'd5;
  localparam logic [2:0] M_DONE         = 3'd6;
  localparam logic [2:0] M_ERROR        = 3'd7;

  // Character codes.
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;

  // Top six bits of high and low surrogates.
  localparam logic [5:0] SurHiTag = 6'b110110;
  localparam logic [5:0] SurLoTag = 6'b110111;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      len;
  } utf8_t;

  // Hex digit value, bit 4 set when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  // UTF-8 encoding of a 16-bit code point, one to three bytes.
  function automatic utf8_t enc16(logic [15:0] v);
    utf8_t e;
    e = '0;
    if (v < 16'h0080) begin
      e.b[0] = v[7:0];
      e.len  = 2'd1;
    end else if (v < 16'h0800) begin
      e.b[0] = {3'b110, v[10:6]};
      e.b[1] = {2'b10, v[5:0]};
      e.len  = 2'd2;
    end else begin
      e.b[0] = {4'hE, v[15:12]};
      e.b[1] = {2'b10, v[11:6]};
      e.b[2] = {2'b10, v[5:0]};
      e.len  = 2'd3;
    end
    return e;
  endfunction

  logic [2:0]  mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] pend_q, pend_d;

  logic [4:0]  hex_d;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;
  utf8_t       enc_acc;

  // Plain-byte handling.
  logic [2:0] nrm_mode;
  logic       nrm_put;
  logic       nrm_fail;
  logic [1:0] nrm_st;

  // Escape-letter handling.
  logic [2:0] esc_mode;
  logic       esc_put;
  logic       esc_fail;
  logic [7:0] esc_byte;

  logic       fail;
  jsu_entry_t ent;

  assign hex_d   = hex_value(in_byte_i);
  assign acc_new = {acc_q[11:0], hex_d[3:0]};
  assign enc_acc = enc16(acc_new);
  assign pair_cp = 21'h10000 + {1'b0, pend_q[9:0], acc_new[9:0]};

  // Classify a byte in normal mode.
  always_comb begin
    nrm_mode = M_NORMAL;
    nrm_put  = 1'b0;
    nrm_fail = 1'b0;
    nrm_st   = ST_MORE;
    if (in_byte_i == ChQuote) begin
      nrm_mode = M_DONE;
      nrm_st   = ST_DONE;
    end else if (in_byte_i == ChBslash) begin
      nrm_mode = M_ESC;
    end else if (in_byte_i < ChSpace) begin
      nrm_fail = 1'b1;
    end else begin
      nrm_put = 1'b1;
    end
  end

  // Classify an escape letter.
  always_comb begin
    esc_mode = M_NORMAL;
    esc_put  = 1'b1;
    esc_fail = 1'b0;
    esc_byte = in_byte_i;
    unique case (in_byte_i)
      ChU: begin
        esc_mode = M_HEX1;
        esc_put  = 1'b0;
      end
      ChQuote, ChBslash, ChSlash: esc_byte = in_byte_i;
      8'h62: esc_byte = 8'h08;
      8'h66: esc_byte = 8'h0C;
      8'h6E: esc_byte = 8'h0A;
      8'h72: esc_byte = 8'h0D;
      8'h74: esc_byte = 8'h09;
      default: begin
        esc_put  = 1'b0;
        esc_fail = 1'b1;
      end
    endcase
  end

  // Main decode step: next state and the output bytes of this item.
  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    ent        = '0;
    ent.status = ST_MORE;
    fail       = 1'b0;

    priority if (mode_q == M_DONE) begin
      ent.status = ST_DONE;
    end else if (mode_q == M_ERROR || text_end_i) begin
      fail = 1'b1;
    end else begin
      unique case (mode_q)
        M_NORMAL: begin
          mode_d        = nrm_mode;
          fail          = nrm_fail;
          ent.status    = nrm_st;
          ent.bytes[0]  = in_byte_i;
          ent.nbytes    = {2'b00, nrm_put};
        end
        M_ESC: begin
          mode_d       = esc_mode;
          fail         = esc_fail;
          ent.bytes[0] = esc_byte;
          ent.nbytes   = {2'b00, esc_put};
          if (esc_mode == M_HEX1) begin
            acc_d = '0;
            cnt_d = '0;
          end
        end
        M_HEX1: begin
          if (hex_d[4]) begin
            fail = 1'b1;
          end else begin
            acc_d = acc_new;
            if (cnt_q == 2'd3) begin
              cnt_d = '0;
              if (acc_new[15:10] == SurHiTag) begin
                pend_d = acc_new;
                mode_d = M_AFTER_HIGH;
              end else begin
                for (int k = 0; k < 3; k++) begin
                  ent.bytes[k] = enc_acc.b[k];
                end
                ent.nbytes = {1'b0, enc_acc.len};
                mode_d     = M_NORMAL;
              end
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
        end
        M_AFTER_HIGH: begin
          if (in_byte_i == ChBslash) begin
            mode_d = M_AFTER_HIGH_BS;
          end else begin
            // Release the held surrogate, then handle the byte as plain text.
            ent.bytes[0] = {4'hE, pend_q[15:12]};
            ent.bytes[1] = {2'b10, pend_q[11:6]};
            ent.bytes[2] = {2'b10, pend_q[5:0]};
            ent.bytes[3] = in_byte_i;
            ent.nbytes   = 3'd3 + {2'b00, nrm_put};
            ent.status   = nrm_st;
            mode_d       = nrm_mode;
            fail         = nrm_fail;
          end
        end
        M_AFTER_HIGH_BS: begin
          if (in_byte_i == ChU) begin
            mode_d = M_HEX2;
            acc_d  = '0;
            cnt_d  = '0;
          end else begin
            // Release the held surrogate, then treat the byte as an escape.
            ent.bytes[0] = {4'hE, pend_q[15:12]};
            ent.bytes[1] = {2'b10, pend_q[11:6]};
            ent.bytes[2] = {2'b10, pend_q[5:0]};
            ent.bytes[3] = esc_byte;
            ent.nbytes   = 3'd3 + {2'b00, esc_put};
            mode_d       = esc_mode;
            fail         = esc_fail;
          end
        end
        M_HEX2: begin
          if (hex_d[4]) begin
            fail = 1'b1;
          end else begin
            acc_d = acc_new;
            if (cnt_q == 2'd3) begin
              cnt_d  = '0;
              mode_d = M_NORMAL;
              if (acc_new[15:10] == SurLoTag) begin
                // Surrogate pair combines into one supplementary code point.
                ent.bytes[0] = {5'b11110, pair_cp[20:18]};
                ent.bytes[1] = {2'b10, pair_cp[17:12]};
                ent.bytes[2] = {2'b10, pair_cp[11:6]};
                ent.bytes[3] = {2'b10, pair_cp[5:0]};
                ent.nbytes   = 3'd4;
              end else begin
                // Unpaired: the high surrogate alone, then the second value.
                ent.bytes[0] = {4'hE, pend_q[15:12]};
                ent.bytes[1] = {2'b10, pend_q[11:6]};
                ent.bytes[2] = {2'b10, pend_q[5:0]};
                for (int k = 0; k < 3; k++) begin
                  ent.bytes[3+k] = enc_acc.b[k];
                end
                ent.nbytes = 3'd3 + {1'b0, enc_acc.len};
              end
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
        end
        default: fail = 1'b1;
      endcase
    end

    // An error drops every byte of this item and sticks.
    if (fail) begin
      mode_d     = M_ERROR;
      ent        = '0;
      ent.status = ST_ERR;
    end
  end

  assign entry_o = ent;

  // Decoder state advances on each accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      acc_q  <= '0;
      cnt_q  <= '0;
      pend_q <= '0;
    end else if (push_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  `JSU_ASSERT_NEXT(a_error_sticky, mode_q == M_ERROR, mode_q == M_ERROR,
                   "error mode was left")
  `JSU_ASSERT_NEXT(a_done_sticky, mode_q == M_DONE, mode_q == M_DONE,
                   "done mode was left")
  `JSU_ASSERT_IMPL(a_err_no_bytes, push_i && ent.status == ST_ERR, ent.nbytes == 3'd0,
                   "error item carries bytes")

endmodule

// File: rtl/jsu_fifo.sv
// Short queue of decoded entries between the front end and the serializer.
// Depends on jsu_pkg for the entry type.
module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  jsu_entry_t push_entry_i,
  input  logic       pop_i,
  output jsu_entry_t head_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// Serializer: walks the bytes of the head queue entry into the output register.
// Emits one result per cycle unless empty or stalled; depends on jsu_pkg.
`include "assert_macros.svh"

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jsu_entry_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       bv_q;
  logic [1:0] status_q;
  logic       last_q;

  logic load;
  logic take;
  logic is_last;

  // Output register is free when empty or its transfer completes now.
  assign load    = !valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign is_last = (head_i.nbytes == 3'd0) || ((idx_q + 3'd1) == head_i.nbytes);
  assign pop_o   = take && is_last;

  assign valid_d = load ? !empty_i : valid_q;
  assign idx_d   = take ? (is_last ? 3'd0 : idx_q + 3'd1) : idx_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Result payload; a result without a byte carries a zero byte.
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= (head_i.nbytes != 3'd0) ? head_i.bytes[idx_q] : 8'h00;
      bv_q     <= (head_i.nbytes != 3'd0);
      status_q <= head_i.status;
      last_q   <= is_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bv_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  `JSU_ASSERT_IMPL(a_empty_result_zero, valid_q && !bv_q, byte_q == 8'h00,
                   "result without a byte carries a nonzero byte")
  `JSU_ASSERT_IMPL(a_empty_result_last, valid_q && !bv_q, last_q,
                   "result without a byte is not the last one")
  `JSU_ASSERT_IMPL(a_status_code, valid_q,
                   status_q == ST_MORE || status_q == ST_DONE || status_q == ST_ERR,
                   "result carries an unused status code")

endmodule

// File: rtl/json_string_unescape_utf8_core.sv
// Accepted bytes become queue entries; the serializer registers their results.
// Throughput: one byte per cycle while each gives one result and output is not
// stalled; a byte with several results holds the output register till all are out,
// and the entry queue (QueueDepth entries) lets input keep flowing meanwhile.
// Reset: asynchronous, clears decoder mode, queue and output valid at once.
module json_string_unescape_utf8_core
  import jsu_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] text_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] status
  output logic       m_axis_tlast
);

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  jsu_entry_t new_entry;
  jsu_entry_t head;
  logic       byte_valid;
  logic [1:0] status;

  // An input transfer is taken whenever the queue has room.
  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_byte_i  (s_axis_tdata),
    .text_end_i (s_axis_tuser),
    .entry_o    (new_entry)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (new_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (full),
    .empty_o      (empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .byte_valid_o (byte_valid),
    .status_o     (status),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = {status, byte_valid};

endmodule

// File: bench/json_string_unescape_utf8_core_test.sv
// Self-checking bench for json_string_unescape_utf8_core: drives one long string body
// over the input stream and checks every decoded transfer against its own decoder.
// Depends on jsu_pkg for the status codes and on the core's stream ports.
import jsu_pkg::*;

// Characters with a role in the string syntax.
localparam logic [7:0] CH_QUOTE  = 8'h22;
localparam logic [7:0] CH_BSLASH = 8'h5C;
localparam logic [7:0] CH_U      = 8'h75;

typedef enum logic [3:0] {
  MODE_NORMAL, MODE_ESC, MODE_HEX1, MODE_AFTER_HIGH, MODE_AFTER_HIGH_BS,
  MODE_HEX2, MODE_DONE, MODE_ERROR
} dec_mode_e;

typedef struct packed {
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;
} unesc_result_t;

// Decodes the accepted bytes and holds the UTF-8 transfers still owed by the core.
class unescape_scoreboard;
  dec_mode_e     mode;
  logic [15:0]   hex_acc;
  logic [1:0]    hex_cnt;
  logic [15:0]   held_high;
  logic [7:0]    step_bytes[$];
  unesc_result_t owed_q[$];
  int unsigned   mismatch_cnt;

  function new();
    mode = MODE_NORMAL;
    hex_acc = '0;
    hex_cnt = '0;
    held_high = '0;
    mismatch_cnt = 0;
  endfunction

  // Append one byte to the output of the current step.
  function void add_byte(logic [7:0] b);
    step_bytes.insert(step_bytes.size(), b);
  endfunction

  // Encode one code point as UTF-8.
  function void put_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // An error drops whatever this byte produced and sticks.
  function logic [1:0] fail();
    mode = MODE_ERROR;
    step_bytes.delete();
    return ST_ERR;
  endfunction

  function logic [1:0] plain_char(logic [7:0] c);
    if (c == CH_QUOTE) begin
      mode = MODE_DONE;
      return ST_DONE;
    end
    if (c == CH_BSLASH) begin
      mode = MODE_ESC;
      return ST_MORE;
    end
    if (c < 8'h20) return fail();
    add_byte(c);
    mode = MODE_NORMAL;
    return ST_MORE;
  endfunction

  function logic [1:0] escape_char(logic [7:0] c);
    logic [7:0] v;
    if (c == CH_U) begin
      mode = MODE_HEX1;
      hex_acc = '0;
      hex_cnt = '0;
      return ST_MORE;
    end
    case (c)
      CH_QUOTE:  v = CH_QUOTE;
      CH_BSLASH: v = CH_BSLASH;
      "/":       v = 8'h2F;
      "b":       v = 8'h08;
      "f":       v = 8'h0C;
      "n":       v = 8'h0A;
      "r":       v = 8'h0D;
      "t":       v = 8'h09;
      default:   return fail();
    endcase
    add_byte(v);
    mode = MODE_NORMAL;
    return ST_MORE;
  endfunction

  // Shift in one hex digit; returns 1 once the fourth digit is in.
  function bit take_hex(input logic [7:0] c, output bit bad);
    logic [4:0] d;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    else d = 5'd16;
    bad = d[4];
    if (bad) return 1'b0;
    hex_acc = {hex_acc[11:0], d[3:0]};
    if (hex_cnt == 2'd3) begin
      hex_cnt = '0;
      return 1'b1;
    end
    hex_cnt = hex_cnt + 2'd1;
    return 1'b0;
  endfunction

  function logic [1:0] decode(logic [7:0] c, logic text_end);
    bit bad;
    if (mode == MODE_DONE) return ST_DONE;
    if (mode == MODE_ERROR) return fail();
    if (text_end) return fail();
    case (mode)
      MODE_NORMAL: return plain_char(c);
      MODE_ESC: return escape_char(c);
      MODE_HEX1: begin
        if (!take_hex(c, bad)) begin
          if (bad) return fail();
          return ST_MORE;
        end
        if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
          held_high = hex_acc;
          mode = MODE_AFTER_HIGH;
          return ST_MORE;
        end
        put_cp({5'd0, hex_acc});
        mode = MODE_NORMAL;
        return ST_MORE;
      end
      MODE_AFTER_HIGH: begin
        if (c == CH_BSLASH) begin
          mode = MODE_AFTER_HIGH_BS;
          return ST_MORE;
        end
        put_cp({5'd0, held_high});
        return plain_char(c);
      end
      MODE_AFTER_HIGH_BS: begin
        if (c == CH_U) begin
          mode = MODE_HEX2;
          hex_acc = '0;
          hex_cnt = '0;
          return ST_MORE;
        end
        put_cp({5'd0, held_high});
        return escape_char(c);
      end
      default: begin
        if (!take_hex(c, bad)) begin
          if (bad) return fail();
          return ST_MORE;
        end
        // A low surrogate completes the pair; anything else goes out on its own.
        if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
          put_cp(21'h10000 + {1'b0, held_high[9:0], hex_acc[9:0]});
        end else begin
          put_cp({5'd0, held_high});
          put_cp({5'd0, hex_acc});
        end
        mode = MODE_NORMAL;
        return ST_MORE;
      end
    endcase
  endfunction

  // Called for every input transfer the core accepts.
  function void note_input(logic [7:0] c, logic text_end);
    logic [1:0]    st;
    unesc_result_t r;
    step_bytes.delete();
    st = decode(c, text_end);
    if (step_bytes.size() == 0) begin
      r = '{out_byte: 8'h00, byte_valid: 1'b0, status: st, last: 1'b1};
      owed_q.insert(owed_q.size(), r);
    end else begin
      foreach (step_bytes[k]) begin
        r = '{out_byte: step_bytes[k], byte_valid: 1'b1, status: st,
              last: (k == step_bytes.size() - 1)};
        owed_q.insert(owed_q.size(), r);
      end
    end
  endfunction

  // Called for every output transfer; compares with the oldest owed result.
  function void check_result(unesc_result_t got);
    unesc_result_t want;
    if (owed_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected transfer: byte %02h valid %0d status %0d last %0d",
                 got.out_byte, got.byte_valid, got.status, got.last);
      return;
    end
    want = owed_q.pop_front();
    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
        got.status !== want.status || got.last !== want.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display({"mismatch: expected byte %02h valid %0d status %0d last %0d,",
                  " got byte %02h valid %0d status %0d last %0d"},
                 want.out_byte, want.byte_valid, want.status, want.last,
                 got.out_byte, got.byte_valid, got.status, got.last);
    end
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction
endclass

module json_string_unescape_utf8_core_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned BodyItems  = 480;
  localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62,
                                             8'h66, 8'h6E, 8'h72, 8'h74};

  typedef struct packed {
    logic [7:0] ch;
    logic       text_end;
  } text_item_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tuser = 1'b0;    // [0] text_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [2:0] m_axis_tuser;           // [0] byte_valid, [2:1] status
  logic       m_axis_tlast;

  unescape_scoreboard board;
  text_item_t         text_q[$];
  bit                 hold_off_req = 1'b0;
  int unsigned        cycle_cnt = 0;

  json_string_unescape_utf8_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- Text generation -------------------------------------------------

  function automatic void push_char(logic [7:0] c);
    text_item_t it;
    it.ch       = c;
    it.text_end = 1'b0;
    text_q.insert(text_q.size(), it);
  endfunction

  function automatic void push_end();
    text_item_t it;
    it.ch       = 8'($urandom_range(0, 255));
    it.text_end = 1'b1;
    text_q.insert(text_q.size(), it);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void push_hex_digits(logic [15:0] v, int unsigned cnt);
    for (int i = 3; i > 3 - int'(cnt); i--) push_char(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void push_hex4(logic [15:0] v);
    push_char(CH_BSLASH);
    push_char(CH_U);
    push_hex_digits(v, 4);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(16'hD800, 16'hDBFF));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'($urandom_range(16'hDC00, 16'hDFFF));
  endfunction

  function automatic logic [15:0] rand_not_low();
    logic [15:0] v;
    do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
    return v;
  endfunction

  // Code point outside the surrogate range, spread over the three encoded lengths.
  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(0, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      default: begin
        do v = 16'($urandom_range(16'h800, 16'hFFFF));
        while (v >= 16'hD800 && v <= 16'hDFFF);
      end
    endcase
    return v;
  endfunction

  function automatic logic [7:0] rand_letter();
    return ESC_LETTERS[3'($urandom_range(0, 7))];
  endfunction

  function automatic logic [7:0] bad_letter();
    logic [7:0] c;
    bit         known;
    do begin
      c = 8'($urandom_range(0, 255));
      known = (c == CH_U);
      foreach (ESC_LETTERS[k]) if (ESC_LETTERS[k] == c) known = 1'b1;
    end while (known);
    return c;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
    return c;
  endfunction

  // One well-formed piece of string content.
  function automatic void push_token();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      push_char(rand_plain());
    end else if (r < 60) begin
      push_char(CH_BSLASH);
      push_char(rand_letter());
    end else if (r < 75) begin
      push_hex4(rand_bmp());
    end else if (r < 83) begin
      push_hex4(rand_high());
      push_hex4(rand_low());
    end else if (r < 87) begin
      push_hex4(rand_high());
      push_char(rand_plain());
    end else if (r < 91) begin
      push_hex4(rand_high());
      push_char(CH_BSLASH);
      push_char(rand_letter());
    end else if (r < 95) begin
      push_hex4(rand_high());
      push_hex4(($urandom_range(0, 2) == 0) ? rand_high() : rand_not_low());
    end else begin
      push_hex4(rand_low());
    end
  endfunction

  // The string ends once per run: a closing quote or one kind of error, then
  // a few bytes and end markers that must all see the sticky status.
  function automatic void push_ending();
    case ($urandom_range(0, 8))
      0: push_char(CH_QUOTE);
      1: begin
        push_hex4(rand_high());
        push_char(CH_QUOTE);
      end
      2: push_char(8'($urandom_range(0, 31)));
      3: begin
        push_char(CH_BSLASH);
        push_char(bad_letter());
      end
      4: begin
        push_char(CH_BSLASH);
        push_char(CH_U);
        push_hex_digits(rand_bmp(), $urandom_range(0, 3));
        push_char(bad_hex());
      end
      5: begin
        push_hex4(rand_high());
        push_char(CH_BSLASH);
        push_char(CH_U);
        push_hex_digits(rand_low(), $urandom_range(0, 3));
        push_char(bad_hex());
      end
      6: begin
        // End of text in the middle of some construct.
        case ($urandom_range(0, 4))
          0: ;
          1: push_char(CH_BSLASH);
          2: begin
            push_char(CH_BSLASH);
            push_char(CH_U);
            push_hex_digits(rand_bmp(), $urandom_range(0, 3));
          end
          3: push_hex4(rand_high());
          default: begin
            push_hex4(rand_high());
            push_char(CH_BSLASH);
          end
        endcase
        push_end();
      end
      7: begin
        push_hex4(rand_high());
        push_char(8'($urandom_range(0, 31)));
      end
      default: begin
        push_hex4(rand_high());
        push_char(CH_BSLASH);
        push_char(bad_letter());
      end
    endcase
    repeat (8) begin
      if ($urandom_range(0, 1)) push_end();
      else push_char(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---- Driving ---------------------------------------------------------

  // Offer one byte and hold it until the core takes the transfer.
  task automatic send_item(input text_item_t it);
    s_axis_tdata  <= it.ch;
    s_axis_tuser  <= it.text_end;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(it.ch, it.text_end);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    board = new();

    // Extremes of plain bytes, an escaped slash, the largest surrogate pair and
    // the lowest high surrogate released by a plain byte.
    push_char(8'h20);
    push_char(8'hFF);
    push_char(CH_BSLASH);
    push_char("/");
    push_hex4(16'hDBFF);
    push_hex4(16'hDFFF);
    push_hex4(16'hD800);
    push_char("A");
    while (text_q.size() < BodyItems) push_token();
    push_ending();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = 0;
    foreach (text_q[i]) begin
      if (i == 150) hold_off_req = 1'b1;
      if (i == 300) begin
        // Let every owed result come out before going on.
        s_axis_tvalid <= 1'b0;
        wait_drained();
        burst_left = $urandom_range(1, 24);
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 40);
      end
      send_item(text_q[i]);
      burst_left--;
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.mismatch_cnt == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output side: check each transfer, then pick tready for the next edge.
  initial begin
    int unsigned hold_left;
    int unsigned pattern_left;
    int unsigned pattern;
    hold_left = 0;
    pattern_left = 0;
    pattern = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result('{out_byte: m_axis_tdata, byte_valid: m_axis_tuser[0],
                             status: m_axis_tuser[2:1], last: m_axis_tlast});
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = $urandom_range(0, 3);
          pattern_left = $urandom_range(50, 150);
        end
        pattern_left--;
        case (pattern)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= pattern_left[0];
        endcase
      end
    end
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_core.sv
bench/json_string_unescape_utf8_core_test.sv
